// ----- hdl/mecanum_chassis_mixer_macros.svh -----
// Assertion macros shared by the mecanum chassis mixer RTL
`ifndef MECANUM_CHASSIS_MIXER_MACROS_SVH
`define MECANUM_CHASSIS_MIXER_MACROS_SVH

// Check that cond implies prop at every clock edge outside reset
`define MCM_ASSERT_IMPL(label, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error(msg);

// Check that cond implies prop in the following cycle
`define MCM_ASSERT_NEXT(label, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error(msg);

`endif

// ----- hdl/mcm_pkg.sv -----
// Types, constants and helpers for the mecanum chassis mixer
package mcm_pkg;

    localparam int ANG_W = 21;
    localparam int CORDIC_STEPS = 16;

    localparam logic signed [ANG_W-1:0] TWO_PI_Q13  = 21'sd51472;
    localparam logic signed [ANG_W-1:0] PI_Q13      = 21'sd25736;
    localparam logic signed [ANG_W-1:0] HALF_PI_Q13 = 21'sd12868;
    localparam logic signed [ANG_W-1:0] CORDIC_X0   = 21'sd39797;

    localparam logic [1:0] MODE_NO_FORCE  = 2'd0;
    localparam logic [1:0] MODE_SPIN      = 2'd1;
    localparam logic [1:0] MODE_FOLLOW    = 2'd2;
    localparam logic [1:0] MODE_TRANSLATE = 2'd3;

    localparam logic [1:0] CFG_SPIN_BASE  = 2'd0;
    localparam logic [1:0] CFG_SPIN_AMP   = 2'd1;
    localparam logic [1:0] CFG_HEAD_GAIN  = 2'd2;

    localparam logic [12:0] SPIN_BASE_RST = 13'd1200;
    localparam logic [10:0] SPIN_AMP_RST  = 11'd100;
    localparam logic [7:0]  HEAD_GAIN_RST = 8'd3;

    localparam logic signed [ANG_W-1:0] ATAN_Q16 [CORDIC_STEPS] = '{
        21'sd51472, 21'sd30385, 21'sd16055, 21'sd8150, 21'sd4091, 21'sd2047,
        21'sd1024, 21'sd512, 21'sd256, 21'sd128, 21'sd64, 21'sd32,
        21'sd16, 21'sd8, 21'sd4, 21'sd2
    };

    // One CORDIC lane: vector, residual angle and negate flag
    typedef struct packed {
        logic signed [ANG_W-1:0] x;
        logic signed [ANG_W-1:0] y;
        logic signed [ANG_W-1:0] z;
        logic                    neg;
    } mcm_rot_t;

    // Item fields carried alongside the rotation
    typedef struct packed {
        logic [1:0]         mode;
        logic signed [15:0] vx;
        logic signed [15:0] vy;
        logic signed [15:0] h;
        logic signed [18:0] odom_vx;
        logic signed [18:0] odom_vy;
        logic signed [18:0] odom_wz;
    } mcm_pay_t;

    typedef struct packed {
        logic [12:0] spin_base;
        logic [10:0] spin_amp;
        logic [7:0]  head_gain;
    } mcm_cfg_t;

    // Reduce a Q3.13 angle into [-pi/2, pi/2] and seed a CORDIC lane
    function automatic mcm_rot_t mcm_seed(input logic signed [ANG_W-1:0] a);
        logic signed [ANG_W-1:0] r;
        mcm_rot_t                o;
        r = a;
        if (r >= TWO_PI_Q13) r = r - TWO_PI_Q13;
        if (r < 0)           r = r + TWO_PI_Q13;
        if (r > PI_Q13)      r = r - TWO_PI_Q13;
        o.neg = 1'b0;
        if (r > HALF_PI_Q13)
        begin
            r = PI_Q13 - r;
            o.neg = 1'b1;
        end
        else if (r < -HALF_PI_Q13)
        begin
            r = -PI_Q13 - r;
            o.neg = 1'b1;
        end
        o.x = CORDIC_X0;
        o.y = '0;
        o.z = r <<< 3;
        return o;
    endfunction

endpackage

// ----- hdl/mcm_cordic_cell.sv -----
// One CORDIC rotation cell: advances the phase and heading lanes by one step
module mcm_cordic_cell #(
    parameter int STEP = 0
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic              in_valid,
    input  mcm_pkg::mcm_pay_t in_pay,
    input  mcm_pkg::mcm_rot_t in_p,
    input  mcm_pkg::mcm_rot_t in_h,
    output logic              out_valid,
    output mcm_pkg::mcm_pay_t out_pay,
    output mcm_pkg::mcm_rot_t out_p,
    output mcm_pkg::mcm_rot_t out_h
);
    import mcm_pkg::*;

    logic     valid_reg;
    mcm_pay_t pay_reg;
    mcm_rot_t p_reg, p_next;
    mcm_rot_t h_reg, h_next;

    function automatic mcm_rot_t rotate(input mcm_rot_t r);
        mcm_rot_t o;
        o = r;
        if (r.z >= 0)
        begin
            o.x = r.x - (r.y >>> STEP);
            o.y = r.y + (r.x >>> STEP);
            o.z = r.z - ATAN_Q16[STEP];
        end
        else
        begin
            o.x = r.x + (r.y >>> STEP);
            o.y = r.y - (r.x >>> STEP);
            o.z = r.z + ATAN_Q16[STEP];
        end
        return o;
    endfunction

    assign p_next = rotate(in_p);
    assign h_next = rotate(in_h);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (en)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pay_reg <= in_pay;
            p_reg   <= p_next;
            h_reg   <= h_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_pay   = pay_reg;
    assign out_p     = p_reg;
    assign out_h     = h_reg;
endmodule

// ----- hdl/mcm_mix.sv -----
// Rotation, yaw selection and wheel mixing after the CORDIC chain
module mcm_mix (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic              in_valid,
    input  mcm_pkg::mcm_pay_t in_pay,
    input  mcm_pkg::mcm_rot_t in_p,
    input  mcm_pkg::mcm_rot_t in_h,
    input  mcm_pkg::mcm_cfg_t cfg,
    output logic              out_valid,
    output logic              out_enabled,
    output logic [124:0]      out_data
);
    import mcm_pkg::*;

    localparam logic signed [49:0] LIM  = 50'sd45000;
    localparam logic signed [49:0] HALF = 50'sd33554432;

    // stage 1: products
    logic               v1_reg;
    mcm_pay_t           pay1_reg;
    logic signed [37:0] vxc_reg, vys_reg, vxs_reg, vyc_reg;
    logic signed [32:0] amps_reg;
    logic signed [24:0] gh_reg;
    logic signed [ANG_W-1:0] cos_h;
    // stage 2: rotated command and yaw
    logic               v2_reg;
    mcm_pay_t           pay2_reg;
    logic signed [38:0] cx_reg, cy_reg;
    logic signed [49:0] wz_reg, wz_next;
    // stage 3: wheel targets
    logic               v3_reg;
    logic               ena_reg;
    logic [124:0]       data_reg;
    logic signed [49:0] cx26, cy26;
    logic signed [16:0] w_lf, w_lb, w_rf, w_rb;

    function automatic logic signed [16:0] wheel(input logic signed [49:0] v);
        logic signed [49:0] r;
        r = (v + HALF) >>> 26;
        if (r > LIM)  r = LIM;
        if (r < -LIM) r = -LIM;
        return r[16:0];
    endfunction

    assign cos_h = in_h.neg ? -in_h.x : in_h.x;

    always_comb
    begin
        case (pay1_reg.mode)
            MODE_SPIN:   wz_next = (50'(signed'({1'b0, cfg.spin_base})) <<< 26)
                                   + (50'(amps_reg) <<< 10);
            MODE_FOLLOW: wz_next = -50'(gh_reg * pay1_reg.h);
            default:     wz_next = '0;
        endcase
    end

    assign cx26 = 50'(cx_reg) <<< 10;
    assign cy26 = 50'(cy_reg) <<< 10;
    assign w_lf = wheel(cx26 - cy26 + wz_reg);
    assign w_lb = wheel(cx26 + cy26 + wz_reg);
    assign w_rf = wheel(cx26 + cy26 - wz_reg);
    assign w_rb = wheel(cx26 - cy26 - wz_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pay1_reg <= in_pay;
            vxc_reg  <= 38'(in_pay.vx * cos_h);
            vys_reg  <= 38'(in_pay.vy * in_h.y);
            vxs_reg  <= 38'(in_pay.vx * in_h.y);
            vyc_reg  <= 38'(in_pay.vy * cos_h);
            amps_reg <= 33'(signed'({1'b0, cfg.spin_amp}) * in_p.y);
            gh_reg   <= 25'(signed'({1'b0, cfg.head_gain}) * in_pay.h);

            pay2_reg <= pay1_reg;
            cx_reg   <= 39'(vxc_reg) + 39'(vys_reg);
            cy_reg   <= 39'(vyc_reg) - 39'(vxs_reg);
            wz_reg   <= wz_next;

            ena_reg  <= (pay2_reg.mode != MODE_NO_FORCE);
            data_reg <= {pay2_reg.odom_wz, pay2_reg.odom_vy, pay2_reg.odom_vx,
                         w_rb, w_rf, w_lb, w_lf};
        end
    end

    assign out_valid   = v3_reg;
    assign out_enabled = ena_reg;
    assign out_data    = data_reg;
endmodule

// ----- hdl/mecanum_chassis_mixer.sv -----
// Top level of the mecanum chassis mixer: ports, config registers, cell chain
//
// Usage:
//   One command per control tick enters on the s_ stream; the wheel targets,
//   motors-enabled flag and odometry leave on the m_ stream, one result per
//   command, in order.
//   Pipeline: one seed stage, sixteen CORDIC cells, three mixing stages
//   including the output register.
//   Throughput: one item per cycle while m_tready allows; the pipeline holds
//   up to 20 items in flight, each cell rotating phase and heading one step.
//   Configuration: cfg_we writes cfg_data into register cfg_index (0 spin
//   base, 1 spin amplitude, 2 heading gain); other indexes are dropped.
//   Write registers only while no command is in flight.
//   Reset: all stage valids clear and registers return to 1200, 100 and 3.
//   Stall: when the receiver holds m_tready low with a result waiting, the
//   whole chain holds and s_tready drops; nothing is lost or repeated.
//   Wheel targets saturate to +/-45000.
module mecanum_chassis_mixer (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    // vx[15:0] vy[31:16] heading[47:32] phase[63:48]
    // meas lf[80:64] rf[97:81] lb[114:98] rb[131:115], zero fill
    input  logic [135:0] s_tdata,
    // mode[1:0]
    input  logic [1:0]   s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // wheel lf[16:0] lb[33:17] rf[50:34] rb[67:51]
    // odom vx[86:68] vy[105:87] wz[124:106], zero fill
    output logic [127:0] m_tdata,
    // motors_enabled[0]
    output logic         m_tuser,
    input  logic         cfg_we,
    input  logic [1:0]   cfg_index,
    input  logic [12:0]  cfg_data
);
    import mcm_pkg::*;
    `include "mecanum_chassis_mixer_macros.svh"

    mcm_cfg_t cfg_reg;
    logic     en;

    // seed stage
    logic               v0_reg;
    mcm_pay_t           pay0_reg, pay_in;
    mcm_rot_t           p0_reg, h0_reg;
    logic signed [18:0] m_lf, m_rf, m_lb, m_rb;

    // chain taps
    logic     cv [CORDIC_STEPS+1];
    mcm_pay_t cp [CORDIC_STEPS+1];
    mcm_rot_t crp [CORDIC_STEPS+1];
    mcm_rot_t crh [CORDIC_STEPS+1];

    logic         mix_valid;
    logic         mix_ena;
    logic [124:0] mix_data;

    // Advance whenever the output register is empty or being taken
    assign en       = !m_tvalid || m_tready;
    assign s_tready = en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.spin_base <= SPIN_BASE_RST;
            cfg_reg.spin_amp  <= SPIN_AMP_RST;
            cfg_reg.head_gain <= HEAD_GAIN_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_SPIN_BASE: cfg_reg.spin_base <= cfg_data;
                CFG_SPIN_AMP:  cfg_reg.spin_amp  <= cfg_data[10:0];
                CFG_HEAD_GAIN: cfg_reg.head_gain <= cfg_data[7:0];
                default:       ;
            endcase
        end
    end

    // Odometry is exact and needs no rotation: form it on entry
    assign m_lf = 19'(signed'(s_tdata[80:64]));
    assign m_rf = 19'(signed'(s_tdata[97:81]));
    assign m_lb = 19'(signed'(s_tdata[114:98]));
    assign m_rb = 19'(signed'(s_tdata[131:115]));

    always_comb
    begin
        pay_in.mode    = s_tuser;
        pay_in.vx      = signed'(s_tdata[15:0]);
        pay_in.vy      = signed'(s_tdata[31:16]);
        pay_in.h       = signed'(s_tdata[47:32]);
        pay_in.odom_vx = m_lf + m_rf + m_lb + m_rb;
        pay_in.odom_vy = -m_lf + m_rf + m_lb - m_rb;
        pay_in.odom_wz = m_lf - m_rf + m_lb - m_rb;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v0_reg <= 1'b0;
        else if (en)
            v0_reg <= s_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pay0_reg <= pay_in;
            p0_reg   <= mcm_seed(ANG_W'(signed'({1'b0, s_tdata[63:48]})));
            h0_reg   <= mcm_seed(ANG_W'(signed'(s_tdata[47:32])));
        end
    end

    assign cv[0]  = v0_reg;
    assign cp[0]  = pay0_reg;
    assign crp[0] = p0_reg;
    assign crh[0] = h0_reg;

    for (genvar i = 0; i < CORDIC_STEPS; i++)
    begin : g_cell
        mcm_cordic_cell #(.STEP(i)) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .in_valid  (cv[i]),
            .in_pay    (cp[i]),
            .in_p      (crp[i]),
            .in_h      (crh[i]),
            .out_valid (cv[i+1]),
            .out_pay   (cp[i+1]),
            .out_p     (crp[i+1]),
            .out_h     (crh[i+1])
        );
    end

    mcm_mix u_mix (
        .clk         (clk),
        .rst_n       (rst_n),
        .en          (en),
        .in_valid    (cv[CORDIC_STEPS]),
        .in_pay      (cp[CORDIC_STEPS]),
        .in_p        (crp[CORDIC_STEPS]),
        .in_h        (crh[CORDIC_STEPS]),
        .cfg         (cfg_reg),
        .out_valid   (mix_valid),
        .out_enabled (mix_ena),
        .out_data    (mix_data)
    );

    assign m_tvalid = mix_valid;
    assign m_tuser  = mix_ena;
    assign m_tdata  = {3'b000, mix_data};

    `MCM_ASSERT_IMPL(a_stall_has_result, !s_tready, m_tvalid,
        "input stalled with no result waiting")
    `MCM_ASSERT_NEXT(a_hold_when_stalled, m_tvalid && !m_tready, m_tvalid,
        "result dropped while stalled")
    `MCM_ASSERT_IMPL(a_lf_sat, m_tvalid,
        signed'(m_tdata[16:0]) <= 17'sd45000 && signed'(m_tdata[16:0]) >= -17'sd45000,
        "left front target beyond saturation limit")
    `MCM_ASSERT_IMPL(a_rb_sat, m_tvalid,
        signed'(m_tdata[67:51]) <= 17'sd45000 && signed'(m_tdata[67:51]) >= -17'sd45000,
        "right back target beyond saturation limit")
endmodule
